// File: hw/rtl/lru_cache_table_core_assert.svh
// ----------------------------------------------------------------------------
// LRU cache table assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_TABLE_CORE_ASSERT_SVH
`define LRU_CACHE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru cache table assertion failed");

// next-cycle implication, disabled during reset
`define LCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru cache table assertion failed");

`endif

// File: hw/rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache table package
// Sizes, status codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int ENTRIES   = 16;
  localparam int LCT_IDX_W = $clog2(ENTRIES);
  localparam int LCT_OCC_W = $clog2(ENTRIES + 1);
  localparam int LCT_CAP_W = 5;
  localparam int LCT_CMP_W = (LCT_OCC_W > LCT_CAP_W) ? LCT_OCC_W : LCT_CAP_W;
  localparam int KEY_W     = 32;
  localparam int REC_W     = 31;
  localparam int YEAR_W    = 16;
  localparam int STATUS_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    LCT_GET_HIT      = 3'd0,
    LCT_GET_MISS     = 3'd1,
    LCT_PUT_UPDATED  = 3'd2,
    LCT_PUT_INSERTED = 3'd3,
    LCT_PUT_EVICTED  = 3'd4
  } lct_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } lct_state_t;

  localparam logic LCT_CMD_GET = 1'b0;
  localparam logic LCT_CMD_PUT = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [REC_W-1:0]     record;
    logic [YEAR_W-1:0]    year;
    logic [LCT_IDX_W-1:0] rank;
  } lct_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic                 old_found;
    logic [LCT_IDX_W-1:0] old_rank;
    logic                 free_found;
  } lct_search_t;

  typedef struct packed {
    logic hit;
    logic older;
    logic free;
  } lct_match_t;

  typedef struct packed {
    logic                 en;
    logic                 touch;
    logic                 write;
    logic                 insert;
    logic                 evict;
    logic [LCT_IDX_W-1:0] idx;
    logic [LCT_IDX_W-1:0] victim;
    logic [LCT_IDX_W-1:0] hit_rank;
    logic [KEY_W-1:0]     key;
    logic [REC_W-1:0]     record;
    logic [YEAR_W-1:0]    year;
  } lct_apply_t;

endpackage

// File: hw/rtl/lct_match.sv
// ----------------------------------------------------------------------------
// LRU cache table compare unit
// Shared per-entry key match, age compare and free-slot test.
// ----------------------------------------------------------------------------
module lct_match import lct_pkg::*; (
  input  lct_entry_t  entry,
  input  lct_search_t search,
  output lct_match_t  match
);

  assign match.hit   = entry.valid && (entry.key == search.key);
  assign match.older = entry.valid && (!search.old_found || (entry.rank > search.old_rank));
  assign match.free  = !entry.valid && !search.free_found;

endmodule

// File: hw/rtl/lct_store.sv
// ----------------------------------------------------------------------------
// LRU cache table entry store
// Entry payload, valid marks, recency ranks and occupancy count.
// ----------------------------------------------------------------------------
module lct_store import lct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [LCT_IDX_W-1:0] rd_idx,
  output lct_entry_t           rd_entry,
  input  lct_apply_t           apply,
  output logic [LCT_OCC_W-1:0] occupancy
);

  logic [KEY_W-1:0]     keys    [ENTRIES];
  logic [REC_W-1:0]     records [ENTRIES];
  logic [YEAR_W-1:0]    years   [ENTRIES];
  logic [LCT_IDX_W-1:0] ranks   [ENTRIES];
  logic [ENTRIES-1:0]   valid;

  assign rd_entry.valid  = valid[rd_idx];
  assign rd_entry.key    = keys[rd_idx];
  assign rd_entry.record = records[rd_idx];
  assign rd_entry.year   = years[rd_idx];
  assign rd_entry.rank   = ranks[rd_idx];

  always_ff @(posedge clk) begin
    if (apply.en && apply.insert) begin
      keys[apply.idx] <= apply.key;
    end
    if (apply.en && apply.write) begin
      records[apply.idx] <= apply.record;
      years[apply.idx]   <= apply.year;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else if (apply.en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (apply.touch) begin
          if (valid[i] && (ranks[i] < apply.hit_rank)) begin
            ranks[i] <= ranks[i] + LCT_IDX_W'(1);
          end
        end else if (apply.insert) begin
          if (valid[i] && !(apply.evict && (LCT_IDX_W'(i) == apply.victim))) begin
            ranks[i] <= ranks[i] + LCT_IDX_W'(1);
          end
        end
      end
      if (apply.insert && apply.evict) begin
        valid[apply.victim] <= 1'b0;
        ranks[apply.victim] <= '0;
      end
      if (apply.touch) begin
        ranks[apply.idx] <= '0;
      end
      if (apply.insert) begin
        valid[apply.idx] <= 1'b1;
        ranks[apply.idx] <= '0;
        if (!apply.evict) begin
          occupancy <= occupancy + LCT_OCC_W'(1);
        end
      end
    end
  end

endmodule

// File: hw/rtl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// LRU cache table sequencer
// Accepts a transaction, scans the entries one a cycle, commits and reports.
// ----------------------------------------------------------------------------
module lct_ctrl import lct_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic signed [KEY_W-1:0]     key,
  input  logic        [REC_W-1:0]     record_number,
  input  logic        [YEAR_W-1:0]    batch_year,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic        [STATUS_W-1:0]  status,
  output logic        [REC_W-1:0]     hit_record_number,
  output logic        [YEAR_W-1:0]    hit_batch_year,
  output logic signed [KEY_W-1:0]     evicted_key,
  input  logic        [LCT_CAP_W-1:0] capacity,
  input  logic        [LCT_OCC_W-1:0] occupancy,
  output logic        [LCT_IDX_W-1:0] rd_idx,
  input  lct_entry_t                  entry,
  output lct_search_t                 search,
  input  lct_match_t                  match,
  output lct_apply_t                  apply
);

  lct_state_t state, state_next;

  logic                 cmd;
  logic [KEY_W-1:0]     skey;
  logic [REC_W-1:0]     srec;
  logic [YEAR_W-1:0]    syear;
  logic [LCT_IDX_W-1:0] ptr;
  logic                 hit_found, old_found, free_found;
  logic [LCT_IDX_W-1:0] hit_idx, hit_rank, old_idx, old_rank, free_idx;
  logic [REC_W-1:0]     hit_rec;
  logic [YEAR_W-1:0]    hit_year;
  logic [KEY_W-1:0]     old_key;

  logic                 load;
  lct_status_t          res_status;
  logic [REC_W-1:0]     res_rec;
  logic [YEAR_W-1:0]    res_year;
  logic [KEY_W-1:0]     res_evicted;
  logic [LCT_CMP_W-1:0] eff_cap;
  logic                 need_evict;

  assign rd_idx            = ptr;
  assign search.key        = skey;
  assign search.old_found  = old_found;
  assign search.old_rank   = old_rank;
  assign search.free_found = free_found;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = LCT_CMP_W'(1);
    end else if (LCT_CMP_W'(capacity) > LCT_CMP_W'(ENTRIES)) begin
      eff_cap = LCT_CMP_W'(ENTRIES);
    end else begin
      eff_cap = LCT_CMP_W'(capacity);
    end
  end

  assign need_evict = (LCT_CMP_W'(occupancy) >= eff_cap) && old_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    load        = 1'b0;
    apply       = '0;
    apply.key   = skey;
    apply.record = srec;
    apply.year  = syear;
    apply.hit_rank = hit_rank;
    apply.victim = old_idx;
    apply.idx   = hit_idx;
    res_status  = LCT_GET_MISS;
    res_rec     = '0;
    res_year    = '0;
    res_evicted = '0;
    if (cmd == LCT_CMD_GET) begin
      if (hit_found) begin
        res_status  = LCT_GET_HIT;
        res_rec     = hit_rec;
        res_year    = hit_year;
        apply.touch = 1'b1;
      end
    end else if (hit_found) begin
      res_status  = LCT_PUT_UPDATED;
      apply.touch = 1'b1;
      apply.write = 1'b1;
    end else begin
      res_status = LCT_PUT_INSERTED;
      if (need_evict) begin
        res_status   = LCT_PUT_EVICTED;
        res_evicted  = old_key;
        apply.evict  = 1'b1;
        apply.insert = 1'b1;
        apply.write  = 1'b1;
        apply.idx    = (free_found && (free_idx < old_idx)) ? free_idx : old_idx;
      end else if (free_found) begin
        apply.insert = 1'b1;
        apply.write  = 1'b1;
        apply.idx    = free_idx;
      end
    end
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr == LCT_IDX_W'(ENTRIES - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    apply.en = load;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd        <= command;
      skey       <= key;
      srec       <= record_number;
      syear      <= batch_year;
      ptr        <= '0;
      hit_found  <= 1'b0;
      old_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      ptr <= ptr + LCT_IDX_W'(1);
      if (match.hit && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= ptr;
        hit_rank  <= entry.rank;
        hit_rec   <= entry.record;
        hit_year  <= entry.year;
      end
      if (match.older) begin
        old_found <= 1'b1;
        old_idx   <= ptr;
        old_rank  <= entry.rank;
        old_key   <= entry.key;
      end
      if (match.free) begin
        free_found <= 1'b1;
        free_idx   <= ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status            <= res_status;
      hit_record_number <= res_rec;
      hit_batch_year    <= res_year;
      evicted_key       <= res_evicted;
    end
  end

endmodule

// File: hw/rtl/lru_cache_table_core.sv
// ----------------------------------------------------------------------------
// LRU cache table core
// A transaction is accepted in the idle state, then the single compare unit steps
// through the 16 entries one a cycle; the apply state then commits and registers
// the result, waiting while an earlier result is held, before the next is accepted.
// Reset clears valid marks, ranks, occupancy and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_cache_table_core import lct_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic signed [KEY_W-1:0]    key,
  input  logic        [REC_W-1:0]    record_number,
  input  logic        [YEAR_W-1:0]   batch_year,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic        [STATUS_W-1:0] status,
  output logic        [REC_W-1:0]    hit_record_number,
  output logic        [YEAR_W-1:0]   hit_batch_year,
  output logic signed [KEY_W-1:0]    evicted_key,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic        [LCT_CAP_W-1:0] cfg_data
);

  logic [LCT_CAP_W-1:0] capacity_in_use;
  logic [LCT_OCC_W-1:0] occupancy;
  logic [LCT_IDX_W-1:0] rd_idx;
  lct_entry_t           entry;
  lct_search_t          search;
  lct_match_t           match;
  lct_apply_t           apply;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= LCT_CAP_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      capacity_in_use <= cfg_data;
    end
  end

  lct_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .key               (key),
    .record_number     (record_number),
    .batch_year        (batch_year),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .hit_record_number (hit_record_number),
    .hit_batch_year    (hit_batch_year),
    .evicted_key       (evicted_key),
    .capacity          (capacity_in_use),
    .occupancy         (occupancy),
    .rd_idx            (rd_idx),
    .entry             (entry),
    .search            (search),
    .match             (match),
    .apply             (apply)
  );

  lct_match u_match (
    .entry  (entry),
    .search (search),
    .match  (match)
  );

  lct_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (rd_idx),
    .rd_entry  (entry),
    .apply     (apply),
    .occupancy (occupancy)
  );

endmodule

// File: hw/rtl/lct_checker.sv
// ----------------------------------------------------------------------------
// LRU cache table port checker
// Port-level properties of the core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_cache_table_core_assert.svh"

module lct_checker import lct_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic        [STATUS_W-1:0] status,
  input logic        [REC_W-1:0]    hit_record_number,
  input logic        [YEAR_W-1:0]   hit_batch_year,
  input logic signed [KEY_W-1:0]    evicted_key
);

  `LCT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `LCT_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(evicted_key))
  `LCT_ASSERT_SAME(a_status_legal, clk, rst, out_valid, status <= STATUS_W'(LCT_PUT_EVICTED))
  `LCT_ASSERT_SAME(a_evict_key_zero, clk, rst, out_valid && (status != STATUS_W'(LCT_PUT_EVICTED)), evicted_key == '0)
  `LCT_ASSERT_SAME(a_miss_fields_zero, clk, rst, out_valid && (status != STATUS_W'(LCT_GET_HIT)), (hit_record_number == '0) && (hit_batch_year == '0))

endmodule

bind lru_cache_table_core lct_checker u_lct_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .status            (status),
  .hit_record_number (hit_record_number),
  .hit_batch_year    (hit_batch_year),
  .evicted_key       (evicted_key)
);
